// File: hdl/conv_pkg.sv
// Shared types, constants and register codes for the 3x3 convolution block.
`default_nettype none
package conv_pkg;

    localparam int PIXEL_BITS   = 8;
    localparam int COEFF_BITS   = 7;
    localparam int KERNEL_SIZE  = 3;
    localparam int KERNEL_TAPS  = KERNEL_SIZE * KERNEL_SIZE;
    // pixel times signed coefficient, nine terms summed
    localparam int SUM_BITS     = PIXEL_BITS + COEFF_BITS + 4;
    localparam int DIV_BITS     = 8;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT = 1024;

    localparam int DIM_BITS     = 11;
    localparam int MAXV_BITS    = 8;
    localparam int OFFSET_BITS  = 9;
    localparam int KERNEL_BITS  = KERNEL_TAPS * COEFF_BITS;

    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;

    localparam logic [DIM_BITS-1:0]    WIDTH_RST   = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0]    HEIGHT_RST  = DIM_BITS'(1024);
    localparam logic [MAXV_BITS-1:0]   MAXV_RST    = MAXV_BITS'(255);
    localparam logic [DIV_BITS-1:0]    DIVISOR_RST = DIV_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFFSET_RST  = '0;
    localparam logic [KERNEL_BITS-1:0] KERNEL_RST  = KERNEL_BITS'(1) << (4 * COEFF_BITS);

    typedef enum logic [2:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_MAXV    = 3'd2,
        REG_DIVISOR = 3'd3,
        REG_OFFSET  = 3'd4,
        REG_KERNEL  = 3'd5
    } conv_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } conv_state_t;

    typedef struct packed {
        logic                  drain;
        logic [PIXEL_BITS-1:0] pixel;
    } conv_in_t;

    typedef struct packed {
        logic                  last;
        logic [PIXEL_BITS-1:0] result;
    } conv_out_t;

    // controls that every cell of the window chain sees
    typedef struct packed {
        logic                   shift;
        logic                   clear;
        logic [KERNEL_SIZE-1:0] row_en;
    } conv_cell_ctl_t;

endpackage
`default_nettype wire

// File: hdl/image_convolve_3x3_clamp.sv
// Top level of the streaming 3x3 convolution with divide, offset and clamp.
//
// Usage: pixels enter in raster order on s_valid/s_ready/s_data (pixel, drain).
// Results leave on m_valid/m_ready/m_data (result, last); m_data.last marks the
// final pixel of the output image. After the last pixel, send image_width+1
// drain items to flush the results still pending.
// Each result belongs to the input one row plus one pixel earlier.
// Per item: the take and the shift step when it yields no result; when it
// does, also the summing steps of the window chain, the serial divider
// (one quotient bit per cycle plus a hand-over step) and the output step.
// Registers sit on an APB-style port at byte addresses 8*i, 64-bit data;
// write them only while the block is idle. Writing width or height restarts
// the frame. Reset restores the default registers (identity kernel) and
// clears window and counters; line stores stay as they are (rows they feed
// are masked). A stalled receiver holds the result in the output register;
// the next item is still taken and runs up to the point of delivery.
`default_nettype none
module image_convolve_3x3_clamp #(
    parameter int MAX_WIDTH = conv_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire conv_pkg::conv_in_t                  s_data,
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      conv_pkg::conv_out_t                 m_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [conv_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [conv_pkg::APB_DATA_BITS-1:0]  pwdata,
    output      logic [conv_pkg::APB_DATA_BITS-1:0]  prdata,
    output      logic                                pready
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PB  = conv_pkg::PIXEL_BITS;
    localparam int CB  = conv_pkg::COEFF_BITS;
    localparam int SB  = conv_pkg::SUM_BITS;
    localparam int KS  = conv_pkg::KERNEL_SIZE;
    localparam int DMB = conv_pkg::DIM_BITS;
    localparam int MVB = conv_pkg::MAXV_BITS;
    localparam int OB  = conv_pkg::OFFSET_BITS;
    localparam int TB  = SB + 2;

    // ---------------- configuration registers ----------------
    logic [DMB-1:0]                  width_reg, height_reg;
    logic [MVB-1:0]                  maxv_reg;
    logic [conv_pkg::DIV_BITS-1:0]   divisor_reg;
    logic [OB-1:0]                   offset_reg;
    logic [conv_pkg::KERNEL_BITS-1:0] kernel_reg;
    logic                            cfg_wr;
    logic                            cfg_restart;
    conv_pkg::conv_reg_t             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = conv_pkg::conv_reg_t'(paddr[5:3]);
    assign cfg_restart = cfg_wr &&
        (cfg_idx == conv_pkg::REG_WIDTH || cfg_idx == conv_pkg::REG_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= conv_pkg::WIDTH_RST;
            height_reg  <= conv_pkg::HEIGHT_RST;
            maxv_reg    <= conv_pkg::MAXV_RST;
            divisor_reg <= conv_pkg::DIVISOR_RST;
            offset_reg  <= conv_pkg::OFFSET_RST;
            kernel_reg  <= conv_pkg::KERNEL_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                conv_pkg::REG_WIDTH:   width_reg   <= pwdata[DMB-1:0];
                conv_pkg::REG_HEIGHT:  height_reg  <= pwdata[DMB-1:0];
                conv_pkg::REG_MAXV:    maxv_reg    <= pwdata[MVB-1:0];
                conv_pkg::REG_DIVISOR: divisor_reg <= pwdata[conv_pkg::DIV_BITS-1:0];
                conv_pkg::REG_OFFSET:  offset_reg  <= pwdata[OB-1:0];
                conv_pkg::REG_KERNEL:  kernel_reg  <= pwdata[conv_pkg::KERNEL_BITS-1:0];
                default: ;  // addresses past the list: drop the write
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            conv_pkg::REG_WIDTH:   prdata = 64'(width_reg);
            conv_pkg::REG_HEIGHT:  prdata = 64'(height_reg);
            conv_pkg::REG_MAXV:    prdata = 64'(maxv_reg);
            conv_pkg::REG_DIVISOR: prdata = 64'(divisor_reg);
            conv_pkg::REG_OFFSET:  prdata = 64'(offset_reg);
            conv_pkg::REG_KERNEL:  prdata = 64'(kernel_reg);
            default:               prdata = '0;
        endcase
    end

    // effective frame size and divisor: zero counts as one, the size saturates at the limits
    logic [WW-1:0]  w_eff;
    logic [DMB-1:0] h_eff;
    logic [conv_pkg::DIV_BITS-1:0] div_eff;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = DMB'(1);
        end else if (32'(height_reg) > conv_pkg::HEIGHT_LIMIT) begin
            h_eff = DMB'(conv_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = height_reg;
        end
        div_eff = (divisor_reg == '0) ? conv_pkg::DIV_BITS'(1) : divisor_reg;
    end

    // ---------------- control state ----------------
    conv_pkg::conv_state_t state_reg, state_next;
    logic [AW-1:0]  col_reg, col_next;
    logic [DMB-1:0] row_reg, row_next;
    logic [1:0]     sum_cnt_reg, sum_cnt_next;
    logic [PB-1:0]  pix_reg, pix_next;
    logic           last_reg, last_next;
    logic [KS-1:0]  row_en_reg, row_en_next;
    logic [KS-1:0]  col_en_reg, col_en_next;
    logic           m_valid_reg, m_valid_next;
    conv_pkg::conv_out_t m_data_reg, m_data_next;

    logic           in_take;
    logic           out_load;
    logic           frame_end;
    logic           div_start;
    logic           div_busy;
    logic signed [SB:0] quotient;

    assign in_take  = s_valid && s_ready;
    assign out_load = (state_reg == conv_pkg::ST_DONE) && (!m_valid_reg || m_ready);
    assign frame_end = out_load && last_reg;
    assign div_start = (state_reg == conv_pkg::ST_SUM) && (sum_cnt_reg == 2'd3);

    // position of the result this item yields
    logic           is_c0;
    logic           emit;
    logic [DMB-1:0] y_pos;
    logic [AW-1:0]  x_pos;
    logic [AW-1:0]  x_last;
    logic [AW:0]    col_inc;

    always_comb begin
        is_c0  = (col_reg == '0);
        x_last = AW'(w_eff - WW'(1));
        if (is_c0) begin
            emit  = (row_reg >= DMB'(2)) && ((row_reg - DMB'(2)) < h_eff);
            y_pos = row_reg - DMB'(2);
            x_pos = x_last;
        end else begin
            emit  = (row_reg >= DMB'(1)) && ((row_reg - DMB'(1)) < h_eff);
            y_pos = row_reg - DMB'(1);
            x_pos = col_reg - AW'(1);
        end
        col_inc = {1'b0, col_reg} + (AW+1)'(1);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            conv_pkg::ST_IDLE:  if (in_take) state_next = conv_pkg::ST_SHIFT;
            conv_pkg::ST_SHIFT: state_next = emit ? conv_pkg::ST_SUM : conv_pkg::ST_IDLE;
            conv_pkg::ST_SUM:   if (div_start) state_next = conv_pkg::ST_DIV;
            conv_pkg::ST_DIV:   if (!div_busy) state_next = conv_pkg::ST_DONE;
            conv_pkg::ST_DONE:  if (out_load) state_next = conv_pkg::ST_IDLE;
            default:            state_next = conv_pkg::ST_IDLE;
        endcase
    end

    // datapath and counter updates
    logic signed [TB-1:0] t_val;

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        sum_cnt_next = sum_cnt_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        row_en_next  = row_en_reg;
        col_en_next  = col_en_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        t_val = TB'(quotient) + TB'($signed(offset_reg));

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            conv_pkg::ST_IDLE: begin
                // zero the pixel for drain items and for rows past the image
                if (in_take) begin
                    pix_next = (s_data.drain || row_reg >= h_eff) ? '0 : s_data.pixel;
                end
            end
            conv_pkg::ST_SHIFT: begin
                row_en_next = {({1'b0, y_pos} + (DMB+1)'(1)) < {1'b0, h_eff},
                               1'b1, y_pos != '0};
                col_en_next = {col_inc < (AW+1)'(w_eff) || !is_c0 && 
                               ({1'b0, x_pos} + (AW+1)'(1)) < (AW+1)'(w_eff),
                               1'b1, x_pos != '0};
                if (is_c0) begin
                    col_en_next[2] = 1'b0;  // right neighbor of a row end
                end else begin
                    col_en_next[2] = ({1'b0, x_pos} + (AW+1)'(1)) < (AW+1)'(w_eff);
                end
                last_next    = (y_pos == h_eff - DMB'(1)) && (x_pos == x_last);
                sum_cnt_next = '0;
                if (col_inc >= (AW+1)'(w_eff)) begin
                    col_next = '0;
                    row_next = row_reg + DMB'(1);
                end else begin
                    col_next = col_inc[AW-1:0];
                end
            end
            conv_pkg::ST_SUM: begin
                sum_cnt_next = sum_cnt_reg + 2'd1;
            end
            conv_pkg::ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next.last = last_reg;
                    if (t_val < 0) begin
                        m_data_next.result = '0;
                    end else if (t_val > TB'(maxv_reg)) begin
                        m_data_next.result = maxv_reg;
                    end else begin
                        m_data_next.result = t_val[PB-1:0];
                    end
                end
            end
            default: ;
        endcase
        // restart the frame after its last result or a new frame size
        if (frame_end || cfg_restart) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= conv_pkg::ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            sum_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            sum_cnt_reg <= sum_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        pix_reg    <= pix_next;
        last_reg   <= last_next;
        row_en_reg <= row_en_next;
        col_en_reg <= col_en_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == conv_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- line stores ----------------
    // store a: the row above, store b: two rows above
    logic          store_we;
    logic [PB-1:0] rd_a, rd_b;

    assign store_we = (state_reg == conv_pkg::ST_SHIFT);

    conv_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_store_a (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (col_reg),
        .wdata (pix_reg),
        .raddr (col_reg),
        .rdata (rd_a)
    );

    conv_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_store_b (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (col_reg),
        .wdata (rd_a),
        .raddr (col_reg),
        .rdata (rd_b)
    );

    // ---------------- window chain ----------------
    // cell 2 takes the new column, pixels move toward cell 0;
    // partial sums move from cell 0 toward cell 2, one cell per cycle
    conv_pkg::conv_cell_ctl_t cell_ctl;
    logic [KS-1:0][PB-1:0] cell_pix [KS+1];
    logic signed [SB-1:0]  cell_psum [KS+1];

    assign cell_ctl.shift  = store_we;
    assign cell_ctl.clear  = frame_end || cfg_restart;
    assign cell_ctl.row_en = row_en_reg;
    assign cell_pix[KS]    = {pix_reg, rd_a, rd_b};
    assign cell_psum[0]    = '0;

    for (genvar j = 0; j < KS; j++) begin : g_cell
        logic [KS-1:0][CB-1:0] coeff_col;
        for (genvar r = 0; r < KS; r++) begin : g_coeff
            assign coeff_col[r] = kernel_reg[(r*KS + j)*CB +: CB];
        end
        conv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl),
            .col_en   (col_en_reg[j]),
            .pix_in   (cell_pix[j+1]),
            .pix_out  (cell_pix[j]),
            .coeff    (coeff_col),
            .psum_in  (cell_psum[j]),
            .psum_out (cell_psum[j+1])
        );
    end

    conv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cell_psum[KS]),
        .divisor  (div_eff),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // ---------------- assertions ----------------
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> !div_busy)
        else $error("item taken while the divider runs");

    a_take_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> state_reg == conv_pkg::ST_SHIFT)
        else $error("accepted item did not reach the shift step");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (AW+1)'(col_reg) < (AW+1)'(w_eff) || $past(cfg_wr))
        else $error("column counter past the row width");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_end |=> row_reg == '0 && col_reg == '0)
        else $error("frame did not restart after its last result");

endmodule
`default_nettype wire

// File: hdl/conv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module conv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/conv_cell.sv
// One window column: three pixels, their weighted sum and the partial-sum link.
`default_nettype none
module conv_cell (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire conv_pkg::conv_cell_ctl_t                  ctl,
    input  wire logic                                      col_en,
    input  wire logic [conv_pkg::KERNEL_SIZE-1:0][conv_pkg::PIXEL_BITS-1:0] pix_in,
    output      logic [conv_pkg::KERNEL_SIZE-1:0][conv_pkg::PIXEL_BITS-1:0] pix_out,
    input  wire logic [conv_pkg::KERNEL_SIZE-1:0][conv_pkg::COEFF_BITS-1:0] coeff,
    input  wire logic signed [conv_pkg::SUM_BITS-1:0]      psum_in,
    output      logic signed [conv_pkg::SUM_BITS-1:0]      psum_out
);

    localparam int PB = conv_pkg::PIXEL_BITS;
    localparam int CB = conv_pkg::COEFF_BITS;
    localparam int SB = conv_pkg::SUM_BITS;
    localparam int KS = conv_pkg::KERNEL_SIZE;

    logic [KS-1:0][PB-1:0] pix_reg, pix_next;
    logic signed [SB-1:0]  psum_reg, psum_next;
    logic signed [PB+CB:0] prod [KS];

    always_comb begin
        pix_next = pix_reg;
        if (ctl.clear) begin
            pix_next = '0;
        end else if (ctl.shift) begin
            pix_next = pix_in;
        end
    end

    always_comb begin
        psum_next = psum_in;
        for (int r = 0; r < KS; r++) begin
            prod[r] = $signed({1'b0, pix_reg[r]}) * $signed(coeff[r]);
            if (col_en && ctl.row_en[r]) begin
                psum_next = psum_next + SB'(prod[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
        end else begin
            pix_reg <= pix_next;
        end
        psum_reg <= psum_next;
    end

    assign pix_out  = pix_reg;
    assign psum_out = psum_reg;

endmodule
`default_nettype wire

// File: hdl/conv_div.sv
// Radix-2 restoring divider, signed dividend, unsigned divisor, truncating quotient.
`default_nettype none
module conv_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [conv_pkg::SUM_BITS-1:0]  dividend,
    input  wire logic [conv_pkg::DIV_BITS-1:0]         divisor,
    output      logic                                  busy,
    output      logic signed [conv_pkg::SUM_BITS:0]    quotient
);

    localparam int N  = conv_pkg::SUM_BITS;
    localparam int DB = conv_pkg::DIV_BITS;
    localparam int CW = $clog2(N + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [DB-1:0] rem_reg, rem_next;
    logic          neg_reg, neg_next;
    logic [DB:0]   shifted;
    logic [DB+1:0] diff;
    logic          ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[N-1]};
        diff    = {1'b0, shifted} - {2'b0, divisor};
        ge      = !diff[DB+1];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(N);
            rem_next  = '0;
            neg_next  = dividend[N-1];
            quo_next  = dividend[N-1] ? N'(-dividend) : N'(dividend);
        end else if (busy_reg) begin
            rem_next = ge ? diff[DB-1:0] : shifted[DB-1:0];
            quo_next = {quo_reg[N-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule
`default_nettype wire
